// ===== hdl/depth_tested_alpha_blend_rop_assert.svh =====
// Assertion macros shared by the raster output stage modules.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef DEPTH_TESTED_ALPHA_BLEND_ROP_ASSERT_SVH
`define DEPTH_TESTED_ALPHA_BLEND_ROP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DTAB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DTAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dtab_pkg.sv =====
// Shared types, codes and helpers for the raster output stage.
// No dependencies; imported by every module of the block but dtab_ram.
package dtab_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_FB_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FB_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_SC_LEFT     = 3'd2;
  localparam logic [2:0] REG_SC_TOP      = 3'd3;
  localparam logic [2:0] REG_SC_SPAN_X   = 3'd4;
  localparam logic [2:0] REG_SC_SPAN_Y   = 3'd5;
  localparam logic [2:0] REG_DEPTH_LEVEL = 3'd6;

  // Request codes; any other code reads
  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_CLIP   = 2'd1;
  localparam logic [1:0] ST_HIDDEN = 2'd2;

  // ceil(2^24 / 255): exact floor division by 255 for values up to 255*255
  localparam logic [16:0] DIV255_RECIP = 17'd65794;

  typedef enum logic [1:0] {
    KIND_DRAW,
    KIND_CLEAR,
    KIND_READ,
    KIND_CLIP
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [8:0]  fb_width;
    logic [8:0]  fb_height;
    logic [11:0] sc_left;
    logic [11:0] sc_top;
    logic [12:0] sc_span_x;
    logic [12:0] sc_span_y;
    logic [7:0]  depth_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fb_width:    9'd256,
    fb_height:   9'd256,
    sc_left:     12'd0,
    sc_top:      12'd0,
    sc_span_x:   13'd8191,
    sc_span_y:   13'd8191,
    depth_level: 8'd1
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } item_t;

  // Floor of v / 255 for v <= 65025, by reciprocal multiply
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [32:0] prod;
    prod = 33'(v) * 33'(DIV255_RECIP);
    return prod[31:24];
  endfunction

endpackage

// ===== hdl/dtab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtab_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dtab_front.sv =====
// Front end: accepts requests, clips to buffer and scissor, forms the address.
// Depends on dtab_pkg.
module dtab_front
  import dtab_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int unsigned AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic [7:0]        in_src_red,
  input  logic [7:0]        in_src_green,
  input  logic [7:0]        in_src_blue,
  input  logic [7:0]        in_src_alpha,
  input  logic              q_full,
  output logic              q_push,
  output item_t             q_item,
  output logic [AW-1:0]     q_addr
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW = XW + YW + 1;

  logic [13:0]   w_sat, h_sat;
  logic [13:0]   sc_x_end, sc_y_end;
  logic [15:0]   x_u, y_u;
  logic          in_buf, in_sc;
  logic [PW-1:0] prod;
  item_t         item_nxt;
  logic          accept;
  logic          st_valid_nxt;

  logic          st_valid_r;
  item_t         st_item_r;
  logic [AW-1:0] st_prod_r;
  logic [XW-1:0] st_ux_r;

  always_comb begin
    w_sat = (14'(cfg.fb_width) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(cfg.fb_width);
    h_sat = (14'(cfg.fb_height) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(cfg.fb_height);
    sc_x_end = 14'(cfg.sc_left) + 14'(cfg.sc_span_x);
    sc_y_end = 14'(cfg.sc_top) + 14'(cfg.sc_span_y);
    x_u = $unsigned(in_x_pos);
    y_u = $unsigned(in_y_pos);

    in_buf = !x_u[15] && !y_u[15] && (x_u < 16'(w_sat)) && (y_u < 16'(h_sat));
    in_sc  = (x_u >= 16'(cfg.sc_left)) && (x_u < 16'(sc_x_end)) &&
             (y_u >= 16'(cfg.sc_top))  && (y_u < 16'(sc_y_end));

    prod = PW'(y_u[YW-1:0]) * PW'(w_sat[XW:0]);

    item_nxt.red   = in_src_red;
    item_nxt.green = in_src_green;
    item_nxt.blue  = in_src_blue;
    item_nxt.alpha = in_src_alpha;
    if (!in_buf) begin
      item_nxt.kind = KIND_CLIP;
    end else if (in_req_type == REQ_DRAW) begin
      item_nxt.kind = in_sc ? KIND_DRAW : KIND_CLIP;
    end else if (in_req_type == REQ_CLEAR) begin
      item_nxt.kind = KIND_CLEAR;
    end else begin
      item_nxt.kind = KIND_READ;
    end
  end

  assign q_push   = st_valid_r && !q_full;
  assign in_ready = !st_valid_r || q_push;
  assign accept   = in_valid && in_ready;
  assign q_item   = st_item_r;
  assign q_addr   = st_prod_r + AW'(st_ux_r);

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (accept) begin
      st_valid_nxt = 1'b1;
    end else if (q_push) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_item_r <= item_nxt;
      st_prod_r <= AW'(prod);
      st_ux_r   <= x_u[XW-1:0];
    end
  end

endmodule

// ===== hdl/dtab_queue.sv =====
// Short FIFO between the front end and the pixel engine.
// Depends on dtab_pkg and the assertion macro header.
`include "depth_tested_alpha_blend_rop_assert.svh"

module dtab_queue
  import dtab_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  `DTAB_ASSERT_NOW(a_q_no_overflow, push, count_r < CW'(DEPTH), "queue push while full")
  `DTAB_ASSERT_NOW(a_q_no_underflow, pop, count_r != '0, "queue pop while empty")
  `DTAB_ASSERT_NEXT(a_q_count_up, push && !pop, count_r == CW'($past(count_r) + 1'b1),
                    "queue count did not advance on push")

endmodule

// ===== hdl/dtab_back.sv =====
// Pixel engine: reads the stored pixel, depth tests, blends, writes back
// and holds the result. Depends on dtab_pkg and the assertion macro header.
`include "depth_tested_alpha_blend_rop_assert.svh"

module dtab_back
  import dtab_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    depth_level,
  input  logic          q_empty,
  output logic          q_pop,
  input  item_t         q_item,
  input  logic [AW-1:0] q_addr,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [31:0]   color_rdata,
  input  logic [7:0]    depth_rdata,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [31:0]   color_wdata,
  output logic [7:0]    depth_wdata,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_alpha,
  output logic [7:0]    out_depth
);

  back_state_t   state_r, state_nxt;
  item_t         item_r;
  logic [AW-1:0] addr_r;
  logic          hidden_r;
  logic [15:0]   mix_red_r, mix_green_r, mix_blue_r;
  logic [31:0]   pix_r;
  logic [7:0]    dep_r;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    status_r;
  logic [31:0]   res_pix_r;
  logic [7:0]    res_dep_r;

  logic          out_free, finish;
  logic [7:0]    alpha_inv;
  logic [1:0]    status_nxt;
  logic [31:0]   res_pix_nxt;
  logic [7:0]    res_dep_nxt;
  logic          wr_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign alpha_inv = 8'd255 - item_r.alpha;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    finish    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_CALC;
        end
      end
      BK_CALC: begin
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Result and write-back for the item in the last step
  always_comb begin
    status_nxt  = ST_DONE;
    res_pix_nxt = pix_r;
    res_dep_nxt = dep_r;
    wr_nxt      = 1'b0;
    case (item_r.kind)
      KIND_CLIP: begin
        status_nxt  = ST_CLIP;
        res_pix_nxt = '0;
        res_dep_nxt = '0;
      end
      KIND_CLEAR: begin
        res_pix_nxt = '1;
        res_dep_nxt = '0;
        wr_nxt      = 1'b1;
      end
      KIND_DRAW: begin
        if (hidden_r) begin
          status_nxt = ST_HIDDEN;
        end else begin
          res_pix_nxt = {item_r.alpha, div255(mix_red_r), div255(mix_green_r),
                         div255(mix_blue_r)};
          res_dep_nxt = depth_level;
          wr_nxt      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_re      = q_pop;
  assign ram_raddr   = q_addr;
  assign ram_we      = finish && wr_nxt;
  assign ram_waddr   = addr_r;
  assign color_wdata = res_pix_nxt;
  assign depth_wdata = res_dep_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      addr_r <= q_addr;
    end
    if (state_r == BK_CALC) begin
      pix_r       <= color_rdata;
      dep_r       <= depth_rdata;
      hidden_r    <= depth_rdata > depth_level;
      mix_red_r   <= 16'(item_r.red) * 16'(item_r.alpha) +
                     16'(color_rdata[23:16]) * 16'(alpha_inv);
      mix_green_r <= 16'(item_r.green) * 16'(item_r.alpha) +
                     16'(color_rdata[15:8]) * 16'(alpha_inv);
      mix_blue_r  <= 16'(item_r.blue) * 16'(item_r.alpha) +
                     16'(color_rdata[7:0]) * 16'(alpha_inv);
    end
    if (finish) begin
      status_r  <= status_nxt;
      res_pix_r <= res_pix_nxt;
      res_dep_r <= res_dep_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_alpha  = res_pix_r[31:24];
  assign out_red    = res_pix_r[23:16];
  assign out_green  = res_pix_r[15:8];
  assign out_blue   = res_pix_r[7:0];
  assign out_depth  = res_dep_r;

  `DTAB_ASSERT_NOW(a_we_only_on_finish, ram_we, state_r == BK_DONE && out_free,
                   "frame buffer written outside the final step")
  `DTAB_ASSERT_NOW(a_clip_never_writes, state_r == BK_DONE && item_r.kind == KIND_CLIP,
                   !ram_we, "clipped request wrote the frame buffer")
  `DTAB_ASSERT_NEXT(a_pop_starts_calc, q_pop, state_r == BK_CALC && !out_valid_r ||
                    state_r == BK_CALC, "popped item did not advance to the blend step")

endmodule

// ===== hdl/depth_tested_alpha_blend_rop.sv =====
// Raster output stage top level: config registers, front end, queue,
// pixel engine and frame buffer RAMs. Depends on dtab_pkg and all dtab_* modules.
//
//   channel   direction  handshake              payload
//   in_*      input      in_valid / in_ready    req_type, x_pos, y_pos, src_red/green/blue/alpha
//   out_*     output     out_valid / out_ready  status, red, green, blue, alpha, depth
//   config    input      psel+penable+pwrite    paddr, pwdata; prdata reads back
//
// The pixel engine works on one item at a time: RAM read, blend
// products, then divide by 255 and write-back, which waits while a result
// is still held for out_ready; only then does it pop the next item. The front
// end registers each request in its clip stage; an item pushed into an empty
// queue is popped into the engine's read step once the queue registers it,
// and its result is then registered for out_*.
// Reset (rst_n, synchronous) clears control state only; the
// frame buffer is undefined until each pixel is cleared or drawn. The input
// side keeps taking items while a result waits on out_ready, until the
// queue fills.
module depth_tested_alpha_blend_rop
  import dtab_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic [7:0]         in_src_red,
  input  logic [7:0]         in_src_green,
  input  logic [7:0]         in_src_blue,
  input  logic [7:0]         in_src_alpha,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic [7:0]         out_depth,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned QW    = $bits(item_t) + AW;

  cfg_t           cfg_r;
  logic           cfg_we;
  logic [2:0]     cfg_sel;

  logic           q_push, q_full, q_pop, q_empty;
  item_t          fe_item, be_item;
  logic [AW-1:0]  fe_addr, be_addr;
  logic [QW-1:0]  q_rdata;

  logic           ram_re, ram_we;
  logic [AW-1:0]  ram_raddr, ram_waddr;
  logic [31:0]    color_rdata, color_wdata;
  logic [7:0]     depth_rdata, depth_wdata;

  // Configuration: writes land on the access cycle; zero wait states
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_FB_WIDTH:    cfg_r.fb_width    <= pwdata[8:0];
        REG_FB_HEIGHT:   cfg_r.fb_height   <= pwdata[8:0];
        REG_SC_LEFT:     cfg_r.sc_left     <= pwdata[11:0];
        REG_SC_TOP:      cfg_r.sc_top      <= pwdata[11:0];
        REG_SC_SPAN_X:   cfg_r.sc_span_x   <= pwdata[12:0];
        REG_SC_SPAN_Y:   cfg_r.sc_span_y   <= pwdata[12:0];
        REG_DEPTH_LEVEL: cfg_r.depth_level <= pwdata[7:0];
        default: begin
          // unmapped offset: drop the write
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FB_WIDTH:    prdata = CFG_DW'(cfg_r.fb_width);
      REG_FB_HEIGHT:   prdata = CFG_DW'(cfg_r.fb_height);
      REG_SC_LEFT:     prdata = CFG_DW'(cfg_r.sc_left);
      REG_SC_TOP:      prdata = CFG_DW'(cfg_r.sc_top);
      REG_SC_SPAN_X:   prdata = CFG_DW'(cfg_r.sc_span_x);
      REG_SC_SPAN_Y:   prdata = CFG_DW'(cfg_r.sc_span_y);
      REG_DEPTH_LEVEL: prdata = CFG_DW'(cfg_r.depth_level);
      default:         prdata = '0;
    endcase
  end

  // Front end: clip and classify, compute the pixel address
  dtab_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_x_pos     (in_x_pos),
    .in_y_pos     (in_y_pos),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_src_alpha (in_src_alpha),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (fe_item),
    .q_addr       (fe_addr)
  );

  // Decouple classification from the read-modify-write engine
  dtab_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({fe_item, fe_addr}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign be_item = item_t'(q_rdata[QW-1:AW]);
  assign be_addr = q_rdata[AW-1:0];

  // Pixel engine; one item in flight, so no same-pixel forwarding is needed
  dtab_back #(
    .AW (AW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .depth_level (cfg_r.depth_level),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_item      (be_item),
    .q_addr      (be_addr),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .color_rdata (color_rdata),
    .depth_rdata (depth_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .color_wdata (color_wdata),
    .depth_wdata (depth_wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_depth   (out_depth)
  );

  // Frame buffer: ARGB word and depth byte per pixel
  dtab_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_color_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (color_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (color_rdata)
  );

  dtab_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (depth_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (depth_rdata)
  );

endmodule

// ===== verif/tb_depth_tested_alpha_blend_rop.sv =====
// Self-checking testbench for the depth-tested alpha-blend raster output stage.
// Depends on dtab_pkg and the depth_tested_alpha_blend_rop RTL; stands alone otherwise.
module tb_depth_tested_alpha_blend_rop
  import dtab_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Read codes; the package only names draw and clear
  localparam logic [1:0] REQ_READ     = 2'd2;
  localparam logic [1:0] REQ_READ_ALT = 2'd3;

  localparam int unsigned PIXELS         = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 250;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DRAIN_CYCLES   = 30;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DIR_ROWS       = 36;

  typedef struct packed {
    logic [1:0]         req;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } raster_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] depth;
  } pixel_result_t;

  // One row of the directed table: a register write or a request,
  // the latter with an optional hand-written expectation
  typedef struct packed {
    bit            is_reg;
    logic [2:0]    reg_idx;
    logic [31:0]   reg_val;
    raster_req_t   rq;
    bit            has_want;
    pixel_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic signed [15:0] in_x_pos;
  logic signed [15:0] in_y_pos;
  logic [7:0]         in_src_red;
  logic [7:0]         in_src_green;
  logic [7:0]         in_src_blue;
  logic [7:0]         in_src_alpha;

  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic [7:0] out_depth;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Shadow of the register file and of the frame buffer, advanced in
  // request order as each request is generated
  cfg_t        shadow_cfg;
  logic [31:0] color_mem [PIXELS];
  logic [7:0]  depth_mem [PIXELS];
  bit          pixel_written [PIXELS];

  // Pixels expected back from the block, oldest first
  pixel_result_t pending_pixels [$];

  int unsigned mismatches;
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_request;

  stim_row_t dir_tab [DIR_ROWS];

  depth_tested_alpha_blend_rop u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_x_pos     (in_x_pos),
    .in_y_pos     (in_y_pos),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_src_alpha (in_src_alpha),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .out_depth    (out_depth),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Pixel prediction
  // ------------------------------------------------------------------

  // Effective buffer size: the width and height registers saturate at the
  // frame buffer's build size
  function automatic void fb_dims(output int unsigned w, output int unsigned h);
    w = (shadow_cfg.fb_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : shadow_cfg.fb_width;
    h = (shadow_cfg.fb_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : shadow_cfg.fb_height;
  endfunction

  // Clip a request to the buffer, and draws also to the scissor window;
  // return whether it survives and the pixel index it touches
  function automatic bit locate(raster_req_t rq, output int unsigned idx);
    int unsigned w, h;
    int px, py;
    bit in_window;
    fb_dims(w, h);
    px = $signed(rq.x);
    py = $signed(rq.y);
    in_window = px >= 0 && py >= 0 && px < int'(w) && py < int'(h);
    if (in_window && rq.req == REQ_DRAW) begin
      in_window = px >= int'(shadow_cfg.sc_left) &&
                  px < int'(shadow_cfg.sc_left) + int'(shadow_cfg.sc_span_x) &&
                  py >= int'(shadow_cfg.sc_top) &&
                  py < int'(shadow_cfg.sc_top) + int'(shadow_cfg.sc_span_y);
    end
    idx = in_window ? (int'(py) * w + int'(px)) : 0;
    return in_window;
  endfunction

  // (src*a + dst*(255-a)) / 255, truncated
  function automatic logic [7:0] blend_channel(logic [7:0] src, logic [7:0] dst,
                                               logic [7:0] a);
    int unsigned sum;
    sum = int'(src) * int'(a) + int'(dst) * (255 - int'(a));
    return 8'(sum / 255);
  endfunction

  // Apply one request to the shadow frame buffer and return the pixel the
  // block reports for it
  function automatic pixel_result_t apply_raster_op(raster_req_t rq);
    pixel_result_t res;
    int unsigned idx;
    logic [31:0] argb;
    logic [7:0] dep;
    res = '0;
    if (!locate(rq, idx)) begin
      res.status = ST_CLIP;
      return res;
    end
    argb = color_mem[idx];
    dep = depth_mem[idx];
    res.status = ST_DONE;
    if (rq.req == REQ_CLEAR) begin
      argb = '1;
      dep = '0;
    end else if (rq.req == REQ_DRAW) begin
      if (dep > shadow_cfg.depth_level) begin
        res.status = ST_HIDDEN;
      end else begin
        argb = {rq.alpha,
                blend_channel(rq.red, argb[23:16], rq.alpha),
                blend_channel(rq.green, argb[15:8], rq.alpha),
                blend_channel(rq.blue, argb[7:0], rq.alpha)};
        dep = shadow_cfg.depth_level;
      end
    end
    // Hidden draws and reads leave the pixel as it was
    if (res.status == ST_DONE && rq.req inside {REQ_DRAW, REQ_CLEAR}) begin
      color_mem[idx] = argb;
      depth_mem[idx] = dep;
      pixel_written[idx] = 1'b1;
    end
    res.red   = argb[23:16];
    res.green = argb[15:8];
    res.blue  = argb[7:0];
    res.alpha = argb[31:24];
    res.depth = dep;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic stim_row_t req_row(logic [1:0] req, int x, int y, logic [31:0] argb);
    stim_row_t r;
    r = '0;
    r.rq.req   = req;
    r.rq.x     = 16'(x);
    r.rq.y     = 16'(y);
    r.rq.alpha = argb[31:24];
    r.rq.red   = argb[23:16];
    r.rq.green = argb[15:8];
    r.rq.blue  = argb[7:0];
    return r;
  endfunction

  // Attach an expectation that can be read straight off the request
  function automatic stim_row_t known(stim_row_t r, logic [1:0] st, logic [31:0] argb,
                                      logic [7:0] dep);
    r.has_want     = 1'b1;
    r.want.status  = st;
    r.want.alpha   = argb[31:24];
    r.want.red     = argb[23:16];
    r.want.green   = argb[15:8];
    r.want.blue    = argb[7:0];
    r.want.depth   = dep;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [2:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Random request, mostly inside the buffer; reads and draws that would
  // land on a pixel never written turn into clears of that pixel
  function automatic raster_req_t random_request();
    raster_req_t rq;
    int unsigned w, h, r, idx;
    fb_dims(w, h);
    r = $urandom_range(0, 99);
    rq.req = (r < 50) ? REQ_DRAW : (r < 72) ? REQ_CLEAR : (r < 95) ? REQ_READ : REQ_READ_ALT;
    if (w != 0 && h != 0 && $urandom_range(0, 9) != 0) begin
      rq.x = 16'($urandom_range(0, w - 1));
      rq.y = 16'($urandom_range(0, h - 1));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          rq.x = 16'($urandom);
          rq.y = 16'($urandom);
        end
        1: begin
          rq.x = -16'($urandom_range(1, 3));
          rq.y = 16'($urandom_range(0, 255));
        end
        default: begin
          rq.x = 16'($urandom_range(0, 255));
          rq.y = 16'(h + $urandom_range(0, 2));
        end
      endcase
    end
    rq.red   = 8'($urandom);
    rq.green = 8'($urandom);
    rq.blue  = 8'($urandom);
    r = $urandom_range(0, 99);
    rq.alpha = (r < 15) ? 8'h00 : (r < 30) ? 8'hFF : 8'($urandom);
    if (rq.req != REQ_CLEAR && locate(rq, idx) && !pixel_written[idx]) rq.req = REQ_CLEAR;
    return rq;
  endfunction

  // Present one request and hold it until the transfer
  task automatic send_item(raster_req_t rq, pixel_result_t want);
    in_valid     <= 1'b1;
    in_req_type  <= rq.req;
    in_x_pos     <= rq.x;
    in_y_pos     <= rq.y;
    in_src_red   <= rq.red;
    in_src_green <= rq.green;
    in_src_blue  <= rq.blue;
    in_src_alpha <= rq.alpha;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_pixels.push_back(want);
  endtask

  task automatic pause_sender();
    int unsigned gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected pixel has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Setup then access cycle; the register takes the value at the access edge
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FB_WIDTH:    shadow_cfg.fb_width    = val[8:0];
      REG_FB_HEIGHT:   shadow_cfg.fb_height   = val[8:0];
      REG_SC_LEFT:     shadow_cfg.sc_left     = val[11:0];
      REG_SC_TOP:      shadow_cfg.sc_top      = val[11:0];
      REG_SC_SPAN_X:   shadow_cfg.sc_span_x   = val[12:0];
      REG_SC_SPAN_Y:   shadow_cfg.sc_span_y   = val[12:0];
      REG_DEPTH_LEVEL: shadow_cfg.depth_level = val[7:0];
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transfer with the oldest pending pixel
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with no request pending, status expected none actual %0h",
                 $time, out_status);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("status", want.status, out_status);
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("alpha", want.alpha, out_alpha);
        check_field("depth", want.depth, out_depth);
      end
    end
  end

  // Receiver: random stalls, steady stretches, and one long hold-off on
  // request, counted here so the sender keeps offering meanwhile
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
      @(posedge clk);
    end
  end

  // Watchdog: end the run after too many cycles without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin : main_seq
    raster_req_t   rq;
    pixel_result_t pred;
    logic [31:0]   cw, ch, cl, ct, csx, csy, cd;

    mismatches   = 0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    hold_request = 1'b0;
    shadow_cfg   = CFG_RESET;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_req_type  <= REQ_DRAW;
    in_x_pos     <= '0;
    in_y_pos     <= '0;
    in_src_red   <= '0;
    in_src_green <= '0;
    in_src_blue  <= '0;
    in_src_alpha <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset register values
    dir_tab = '{
      known(req_row(REQ_CLEAR, 0, 0, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      known(req_row(REQ_READ, 0, 0, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      // opaque draw replaces the colour and takes the layer depth
      known(req_row(REQ_DRAW, 0, 0, 32'hFF123456), ST_DONE, 32'hFF123456, 8'd1),
      // equal depth does not hide; zero alpha keeps the colour
      req_row(REQ_DRAW, 0, 0, 32'h00ABCDEF),
      known(req_row(REQ_CLEAR, 255, 255, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      req_row(REQ_DRAW, 255, 255, 32'h7F000000),
      req_row(REQ_READ_ALT, 255, 255, 32'h0),
      // buffer bounds and signed positions
      known(req_row(REQ_DRAW, -1, 0, 32'h80FFFFFF), ST_CLIP, 32'h0, 8'd0),
      known(req_row(REQ_READ, 0, -32768, 32'h0), ST_CLIP, 32'h0, 8'd0),
      known(req_row(REQ_CLEAR, 256, 0, 32'h0), ST_CLIP, 32'h0, 8'd0),
      known(req_row(REQ_DRAW, 32767, 32767, 32'hFFFFFFFF), ST_CLIP, 32'h0, 8'd0),
      // a layer below the stored depth hides the draw
      reg_row(REG_DEPTH_LEVEL, 32'd0),
      req_row(REQ_DRAW, 0, 0, 32'h80AAAAAA),
      reg_row(REG_DEPTH_LEVEL, 32'd255),
      // scissor window 10..14 in both directions, draws only
      reg_row(REG_SC_LEFT, 32'd10),
      reg_row(REG_SC_TOP, 32'd10),
      reg_row(REG_SC_SPAN_X, 32'd5),
      reg_row(REG_SC_SPAN_Y, 32'd5),
      known(req_row(REQ_CLEAR, 9, 9, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      known(req_row(REQ_DRAW, 9, 9, 32'hFF00FF00), ST_CLIP, 32'h0, 8'd0),
      known(req_row(REQ_CLEAR, 10, 10, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      known(req_row(REQ_DRAW, 10, 10, 32'hFFC0FFEE), ST_DONE, 32'hFFC0FFEE, 8'd255),
      known(req_row(REQ_CLEAR, 14, 14, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      req_row(REQ_DRAW, 14, 14, 32'h40102030),
      known(req_row(REQ_DRAW, 15, 14, 32'hFFFFFFFF), ST_CLIP, 32'h0, 8'd0),
      // an empty scissor clips every draw
      reg_row(REG_SC_SPAN_X, 32'd0),
      known(req_row(REQ_DRAW, 10, 10, 32'hFFFFFFFF), ST_CLIP, 32'h0, 8'd0),
      // zero width puts everything outside
      reg_row(REG_FB_WIDTH, 32'd0),
      known(req_row(REQ_READ, 0, 0, 32'h0), ST_CLIP, 32'h0, 8'd0),
      // oversize width saturates to the buffer's build width
      reg_row(REG_FB_WIDTH, 32'd511),
      reg_row(REG_FB_HEIGHT, 32'd16),
      known(req_row(REQ_CLEAR, 255, 15, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      known(req_row(REQ_READ, 0, 16, 32'h0), ST_CLIP, 32'h0, 8'd0),
      known(req_row(REQ_READ, 255, 15, 32'h0), ST_DONE, 32'hFFFFFFFF, 8'd0),
      reg_row(REG_FB_HEIGHT, 32'd0),
      known(req_row(REQ_READ, 255, 15, 32'h0), ST_CLIP, 32'h0, 8'd0)
    };

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        wait_drained();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        // run the prediction anyway so the shadow buffer stays current
        pred = apply_raster_op(dir_tab[i].rq);
        send_item(dir_tab[i].rq, dir_tab[i].has_want ? dir_tab[i].want : pred);
        pause_sender();
      end
    end

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          cw = $urandom_range(4, 16); ch = $urandom_range(4, 16);
          cl = 0; ct = 0; csx = 8191; csy = 8191; cd = 200;
        end
        1: begin
          cw = 12; ch = 12;
          cl = $urandom_range(0, 6); ct = $urandom_range(0, 6);
          csx = $urandom_range(2, 8); csy = $urandom_range(2, 8); cd = 60;
        end
        // widest stride, scissor parked at its far corner
        2: begin
          cw = 511; ch = 4; cl = 4095; ct = 4095; csx = 8191; csy = 8191; cd = 255;
        end
        3: begin
          cw = 1; ch = 1; cl = 0; ct = 0; csx = 1; csy = 1; cd = 0;
        end
        4: begin
          cw = 256; ch = 2; cl = 0; ct = 0; csx = 8191; csy = 8191; cd = 255;
        end
        default: begin
          cw = $urandom_range(1, 20); ch = $urandom_range(1, 20);
          cl = $urandom_range(0, 4); ct = $urandom_range(0, 4);
          csx = $urandom_range(0, 24); csy = $urandom_range(0, 24);
          cd = $urandom_range(0, 255);
        end
      endcase
      write_reg(REG_FB_WIDTH, cw);
      write_reg(REG_FB_HEIGHT, ch);
      write_reg(REG_SC_LEFT, cl);
      write_reg(REG_SC_TOP, ct);
      write_reg(REG_SC_SPAN_X, csx);
      write_reg(REG_SC_SPAN_Y, csy);
      write_reg(REG_DEPTH_LEVEL, cd);

      tx_steady = (ph % 4 == 3);
      rx_steady = (ph == 5);
      // back-pressure: hold the receiver off while requests keep coming
      if (ph == 1) begin
        tx_steady    = 1'b1;
        hold_request = 1'b1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rq = random_request();
        pred = apply_raster_op(rq);
        send_item(rq, pred);
        // once mid-phase, let the block run completely dry
        if (ph == 4 && n == PHASE_ITEMS / 2)
          wait_drained();
        else
          pause_sender();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t: pending results expected 0 actual %0d", $time, pending_pixels.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
